### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers shared by the keyboard report RTL.
// Both sample on the rising edge of clock and are off while reset is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent holds, consequent holds in the same cycle
`define ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent holds, consequent holds in the following cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/kbd6_pkg.sv
// ----------------------------------------------------------------------------
// kbd6_pkg
// Types and constants for the six-key boot keyboard report builder.
// ----------------------------------------------------------------------------
`default_nettype none

package kbd6_pkg;

   localparam int SLOT_COUNT = 6;

   // action codes carried in the request
   localparam logic [1:0] ACT_PRESS       = 2'd0;
   localparam logic [1:0] ACT_RELEASE     = 2'd1;
   localparam logic [1:0] ACT_RELEASE_ALL = 2'd2;

   typedef logic [7:0] usage_type;
   typedef usage_type [SLOT_COUNT-1:0] slot_array_type;

   // one key event
   typedef struct packed {
      logic [1:0] action;
      logic [7:0] usage;
      logic [7:0] modifier_bits;
      logic       link_connected;
   } req_type;

   // one boot keyboard report
   typedef struct packed {
      logic [7:0] report_modifiers;
      logic [7:0] slot_zero;
      logic [7:0] slot_one;
      logic [7:0] slot_two;
      logic [7:0] slot_three;
      logic [7:0] slot_four;
      logic [7:0] slot_five;
   } rsp_type;

   // held report state
   typedef struct packed {
      logic [7:0]     modifiers;
      slot_array_type slots;
   } state_type;

   // contents of the input register
   typedef struct packed {
      logic    valid;
      req_type item;
   } in_stage_type;

endpackage

`default_nettype wire

### hw/rtl/kbd6_stream_if.sv
// ----------------------------------------------------------------------------
// kbd6_stream_if
// Valid/ready stream channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface kbd6_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

### hw/rtl/keyboard_six_key_report_builder_top.sv
// ----------------------------------------------------------------------------
// keyboard_six_key_report_builder_top
// Boot keyboard report builder with a modifier byte and six key slots.
// ----------------------------------------------------------------------------
// req_chan takes key events (press, release, release-all) with the usage
// code, modifier bits and host link state; each transfer updates the held
// modifier byte and slots and, with the link up, yields one report on
// rsp_chan with the modifier byte and all six slots. An unused action code
// changes nothing and yields no report; with the link down the state still
// changes but no report is sent.
// Path: an event is captured in the input register, then the slot compare
//   and first-empty select load the report register once that register is
//   free or draining.
// Throughput: one event per cycle while rsp_chan is not stalled.
// Reset: synchronous, active high; clears the modifiers, all slots and both
//   valid flags.
// Stall: while a report waits on rsp_chan, one more event waits in the
//   input register and req_chan.ready then drops.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module keyboard_six_key_report_builder_top (
   input  wire logic     clock,
   input  wire logic     reset,
   kbd6_stream_if.sink   req_chan,
   kbd6_stream_if.source rsp_chan
);

   kbd6_pkg::in_stage_type stage;
   kbd6_pkg::state_type    state_ff;
   kbd6_pkg::state_type    state_in;
   kbd6_pkg::rsp_type      rsp_ff;
   logic                   rsp_vld_ff;
   logic                   rsp_vld_in;
   logic                   emit;
   logic                   advance;

   kbd6_in_reg u_in_reg (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .advance  (advance),
      .stage    (stage)
   );

   kbd6_slot_logic u_slot_logic (
      .item (stage.item),
      .cur  (state_ff),
      .nxt  (state_in),
      .emit (emit)
   );

   // an event retires when the report register is free or draining
   assign advance    = stage.valid && (!rsp_vld_ff || rsp_chan.ready);
   assign rsp_vld_in = advance ? emit : (rsp_vld_ff && !rsp_chan.ready);

   // held state and report valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // report payload
   always_ff @(posedge clock) begin
      if (advance && emit) begin
         rsp_ff.report_modifiers <= state_in.modifiers;
         rsp_ff.slot_zero        <= state_in.slots[0];
         rsp_ff.slot_one         <= state_in.slots[1];
         rsp_ff.slot_two         <= state_in.slots[2];
         rsp_ff.slot_three       <= state_in.slots[3];
         rsp_ff.slot_four        <= state_in.slots[4];
         rsp_ff.slot_five        <= state_in.slots[5];
      end
   end

   assign rsp_chan.valid   = rsp_vld_ff;
   assign rsp_chan.payload = rsp_ff;

   // release-all leaves an empty report state
   `ASSERT_NEXT(a_release_all_clears, advance && stage.item.action == kbd6_pkg::ACT_RELEASE_ALL, state_ff == '0, "release-all left state")

   // a new report only comes from a retiring event
   `ASSERT_NEXT(a_report_source, !rsp_vld_ff && !advance, !rsp_vld_ff, "report without event")

   // a pending report is never dropped before transfer
   `ASSERT_SAME(a_no_overwrite, advance && emit && rsp_vld_ff, rsp_chan.ready, "report overwritten")

endmodule

`default_nettype wire

### hw/rtl/kbd6_in_reg.sv
// ----------------------------------------------------------------------------
// kbd6_in_reg
// Input register for key events; holds an event until the core consumes it.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module kbd6_in_reg (
   input  wire logic                   clock,
   input  wire logic                   reset,
   kbd6_stream_if.sink                 req_chan,
   input  wire logic                   advance,
   output kbd6_pkg::in_stage_type      stage
);

   logic              in_vld_ff;
   logic              in_vld_in;
   kbd6_pkg::req_type in_item_ff;
   logic              take;

   // accept whenever the register is empty or drains this cycle
   assign req_chan.ready = !in_vld_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;
   assign in_vld_in      = take || (in_vld_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   // payload capture
   always_ff @(posedge clock) begin
      if (take) begin
         in_item_ff <= req_chan.payload;
      end
   end

   assign stage.valid = in_vld_ff;
   assign stage.item  = in_item_ff;

   // a held event is neither lost nor overwritten
   `ASSERT_NEXT(a_hold_event, in_vld_ff && !advance, in_vld_ff && $stable(in_item_ff), "held event changed")

endmodule

`default_nettype wire

### hw/rtl/kbd6_slot_logic.sv
// ----------------------------------------------------------------------------
// kbd6_slot_logic
// Next-state logic: six parallel slot compares and first-empty select.
// ----------------------------------------------------------------------------
`default_nettype none

module kbd6_slot_logic (
   input  kbd6_pkg::req_type   item,
   input  kbd6_pkg::state_type cur,
   output kbd6_pkg::state_type nxt,
   output logic                emit
);

   logic [kbd6_pkg::SLOT_COUNT-1:0] hit;
   logic [kbd6_pkg::SLOT_COUNT-1:0] empty;
   logic [kbd6_pkg::SLOT_COUNT-1:0] first_empty;
   logic                            any_hit;
   logic                            add_ok;

   // per-slot compares
   always_comb begin
      for (int i = 0; i < kbd6_pkg::SLOT_COUNT; i++) begin
         hit[i]   = (cur.slots[i] == item.usage);
         empty[i] = (cur.slots[i] == 8'd0);
      end
   end

   // lowest empty slot, one-hot
   always_comb begin
      logic seen;
      seen        = 1'b0;
      first_empty = '0;
      for (int i = 0; i < kbd6_pkg::SLOT_COUNT; i++) begin
         if (empty[i] && !seen) begin
            first_empty[i] = 1'b1;
            seen           = 1'b1;
         end
      end
   end

   assign any_hit = |hit;
   assign add_ok  = (item.usage != 8'd0) && !any_hit;

   // apply the action
   always_comb begin
      nxt  = cur;
      emit = 1'b0;
      case (item.action)
         kbd6_pkg::ACT_PRESS: begin
            nxt.modifiers = cur.modifiers | item.modifier_bits;
            for (int i = 0; i < kbd6_pkg::SLOT_COUNT; i++) begin
               if (add_ok && first_empty[i]) begin
                  nxt.slots[i] = item.usage;
               end
            end
            emit = item.link_connected;
         end
         kbd6_pkg::ACT_RELEASE: begin
            for (int i = 0; i < kbd6_pkg::SLOT_COUNT; i++) begin
               if (hit[i]) begin
                  nxt.slots[i] = 8'd0;
               end
            end
            emit = item.link_connected;
         end
         kbd6_pkg::ACT_RELEASE_ALL: begin
            nxt  = '0;
            emit = item.link_connected;
         end
         default: begin
            nxt  = cur;
            emit = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the six-key boot keyboard report builder.
// ----------------------------------------------------------------------------
// A directed run covers modifier OR-in, duplicate presses, a full slot table,
// releases of held and unheld usages, release-all, the unused action code and
// events with the link down. A long random run follows, built mostly from a
// small set of usages so that slots fill, repeat and free up. Each event
// transfer is fed to an in-bench model of the held state. Every report
// transfer is checked field by field against the oldest predicted report.
// Both channels idle at random, with calm windows in which neither side idles.
// ----------------------------------------------------------------------------

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam int RANDOM_EVENTS = 800;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int SETTLE_CYCLES = 8;

   typedef struct {
      kbd6_pkg::req_type item;
      bit                hold_for_drain;
   } key_stroke_type;

   logic clock;
   logic reset;

   kbd6_stream_if #(.payload_type(kbd6_pkg::req_type)) req_chan ();
   kbd6_stream_if #(.payload_type(kbd6_pkg::rsp_type)) rsp_chan ();

   keyboard_six_key_report_builder_top u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   key_stroke_type    pending_strokes[$];
   kbd6_pkg::rsp_type expected_reports[$];

   // model of the held report state
   logic [7:0]          model_mods = '0;
   kbd6_pkg::usage_type model_slots [kbd6_pkg::SLOT_COUNT] = '{default: '0};

   string report_field_name [kbd6_pkg::SLOT_COUNT+1] = '{"report_modifiers",
      "slot_zero", "slot_one", "slot_two", "slot_three", "slot_four", "slot_five"};

   int  mismatch_count = 0;
   int  cycle_count    = 0;
   bit  req_taken      = 1'b0;
   int  req_gap        = 0;
   int  rsp_stall      = 0;

   // clock, reset and known input levels from time zero
   initial begin
      clock             = 1'b0;
      reset             = 1'b1;
      req_chan.valid    = 1'b0;
      req_chan.payload  = '0;
      rsp_chan.ready    = 1'b0;
      fork
         forever #1 clock = ~clock;
         begin
            repeat (2) @(posedge clock);
            @(negedge clock);
            reset <= 1'b0;
         end
      join_none
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t mismatch: %s got %h want %h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // apply one event to the model and queue the report it yields
   task automatic predict_report(input kbd6_pkg::req_type ev);
      kbd6_pkg::rsp_type rep;
      bit                already_held;
      int                free_slot;
      case (ev.action)
         kbd6_pkg::ACT_PRESS: begin
            model_mods = model_mods | ev.modifier_bits;
            already_held = 1'b0;
            free_slot = -1;
            for (int i = 0; i < kbd6_pkg::SLOT_COUNT; i++) begin
               if (model_slots[i] == ev.usage) already_held = 1'b1;
               if (model_slots[i] == '0 && free_slot < 0) free_slot = i;
            end
            // usage zero and a full table both leave the slots alone
            if (ev.usage != '0 && !already_held && free_slot >= 0)
               model_slots[free_slot] = ev.usage;
         end
         kbd6_pkg::ACT_RELEASE: begin
            for (int i = 0; i < kbd6_pkg::SLOT_COUNT; i++)
               if (model_slots[i] == ev.usage) model_slots[i] = '0;
         end
         kbd6_pkg::ACT_RELEASE_ALL: begin
            model_mods = '0;
            for (int i = 0; i < kbd6_pkg::SLOT_COUNT; i++) model_slots[i] = '0;
         end
         default: return;
      endcase
      if (!ev.link_connected) return;
      rep.report_modifiers = model_mods;
      rep.slot_zero        = model_slots[0];
      rep.slot_one         = model_slots[1];
      rep.slot_two         = model_slots[2];
      rep.slot_three       = model_slots[3];
      rep.slot_four        = model_slots[4];
      rep.slot_five        = model_slots[5];
      expected_reports = {expected_reports, rep};
   endtask

   // compare one report transfer with the oldest prediction
   task automatic check_report(input kbd6_pkg::rsp_type got);
      logic [55:0] got_bits;
      logic [55:0] want_bits;
      got_bits = got;
      if (expected_reports.size() == 0) begin
         report_mismatch("report with none expected", 64'(got_bits), '0);
         return;
      end
      want_bits = expected_reports.pop_front();
      for (int i = 0; i <= kbd6_pkg::SLOT_COUNT; i++)
         if (got_bits[55-8*i -: 8] !== want_bits[55-8*i -: 8])
            report_mismatch(report_field_name[i], 64'(got_bits[55-8*i -: 8]),
                            64'(want_bits[55-8*i -: 8]));
   endtask

   // idle length: mostly short, a few long, none inside calm windows
   function automatic int next_gap();
      int r;
      if ((cycle_count % 600) < 90) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic add_stroke(input logic [1:0] act, input logic [7:0] code,
                             input logic [7:0] mods, input logic link,
                             input bit hold);
      key_stroke_type s;
      s.item.action         = act;
      s.item.usage          = code;
      s.item.modifier_bits  = mods;
      s.item.link_connected = link;
      s.hold_for_drain      = hold;
      pending_strokes = {pending_strokes, s};
   endtask

   // event driver: changes on the falling edge
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (req_chan.valid && !req_taken) begin
         // transfer not taken yet, hold the item
      end else begin
         if (req_taken) req_gap = next_gap();
         if (req_gap > 0) begin
            req_gap--;
            req_chan.valid <= 1'b0;
         end else if (pending_strokes.size() == 0 ||
                      (pending_strokes[0].hold_for_drain &&
                       expected_reports.size() != 0)) begin
            req_chan.valid <= 1'b0;
         end else begin
            req_chan.valid   <= 1'b1;
            req_chan.payload <= pending_strokes[0].item;
         end
      end
   end

   // report ready: random stalls
   always @(negedge clock) begin
      if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= 1'b1;
         rsp_stall = next_gap();
      end
   end

   // monitor: both handshakes on the rising edge
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) check_report(rsp_chan.payload);
         req_taken <= req_chan.valid && req_chan.ready;
         if (req_chan.valid && req_chan.ready) begin
            predict_report(req_chan.payload);
            void'(pending_strokes.pop_front());
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** keyboard_six_key_report_builder_top: FAILED **");
         $finish;
      end
   end

   // stimulus and end of run
   initial begin
      int         counted;
      int         r;
      logic [1:0] act;
      logic [7:0] code;
      logic [7:0] mods;
      logic       link;

      // modifier OR-in, duplicate press, press with usage zero
      add_stroke(kbd6_pkg::ACT_PRESS,   8'h04, 8'h01, 1'b1, 1'b0);
      add_stroke(kbd6_pkg::ACT_PRESS,   8'h04, 8'h02, 1'b1, 1'b0);
      add_stroke(kbd6_pkg::ACT_PRESS,   8'h00, 8'h80, 1'b1, 1'b0);
      // fill all six slots, then overflow is dropped
      add_stroke(kbd6_pkg::ACT_PRESS,   8'h05, 8'h00, 1'b1, 1'b0);
      add_stroke(kbd6_pkg::ACT_PRESS,   8'h06, 8'h00, 1'b1, 1'b0);
      add_stroke(kbd6_pkg::ACT_PRESS,   8'h07, 8'h00, 1'b1, 1'b0);
      add_stroke(kbd6_pkg::ACT_PRESS,   8'h08, 8'h00, 1'b1, 1'b0);
      add_stroke(kbd6_pkg::ACT_PRESS,   8'h09, 8'h00, 1'b1, 1'b0);
      add_stroke(kbd6_pkg::ACT_PRESS,   8'hFF, 8'h40, 1'b1, 1'b0);
      // a freed middle slot is reused first
      add_stroke(kbd6_pkg::ACT_RELEASE, 8'h06, 8'h00, 1'b1, 1'b0);
      add_stroke(kbd6_pkg::ACT_PRESS,   8'hFF, 8'h00, 1'b1, 1'b0);
      // release of usage zero and of a usage not held
      add_stroke(kbd6_pkg::ACT_RELEASE, 8'h00, 8'h00, 1'b1, 1'b0);
      add_stroke(kbd6_pkg::ACT_RELEASE, 8'h3A, 8'h00, 1'b1, 1'b0);
      // modifiers are ignored on release
      add_stroke(kbd6_pkg::ACT_RELEASE, 8'h04, 8'hFF, 1'b1, 1'b0);
      add_stroke(ACT_UNUSED,            8'h07, 8'hFF, 1'b1, 1'b0);
      // link down still updates state
      add_stroke(kbd6_pkg::ACT_PRESS,   8'h0A, 8'h10, 1'b0, 1'b0);
      add_stroke(kbd6_pkg::ACT_RELEASE, 8'h05, 8'h00, 1'b0, 1'b0);
      add_stroke(kbd6_pkg::ACT_PRESS,   8'h0B, 8'h00, 1'b1, 1'b0);
      add_stroke(kbd6_pkg::ACT_RELEASE_ALL, 8'hFF, 8'hFF, 1'b1, 1'b0);
      add_stroke(kbd6_pkg::ACT_PRESS,   8'hFF, 8'hFF, 1'b1, 1'b0);
      add_stroke(kbd6_pkg::ACT_PRESS,   8'h01, 8'h00, 1'b1, 1'b0);
      add_stroke(kbd6_pkg::ACT_RELEASE, 8'hFF, 8'h00, 1'b1, 1'b0);
      add_stroke(kbd6_pkg::ACT_RELEASE_ALL, 8'h00, 8'h00, 1'b0, 1'b0);
      add_stroke(ACT_UNUSED,            8'h00, 8'h00, 1'b0, 1'b0);

      // random events over a small usage set so slots fill and repeat
      counted = 0;
      while (counted < RANDOM_EVENTS) begin
         r = $urandom_range(0, 99);
         if (r < 50)      act = kbd6_pkg::ACT_PRESS;
         else if (r < 85) act = kbd6_pkg::ACT_RELEASE;
         else if (r < 95) act = kbd6_pkg::ACT_RELEASE_ALL;
         else             act = ACT_UNUSED;
         r = $urandom_range(0, 99);
         if (r < 70)      code = 8'($urandom_range(1, 9));
         else if (r < 78) code = '0;
         else             code = 8'($urandom_range(0, 255));
         r = $urandom_range(0, 99);
         if (r < 45)      mods = '0;
         else if (r < 80) mods = 8'(1 << $urandom_range(0, 7));
         else             mods = 8'($urandom_range(0, 255));
         link = ($urandom_range(0, 99) < 88);
         // events added at count zero or at the midpoint wait for all reports to drain
         add_stroke(act, code, mods, link, counted == 0 || counted == RANDOM_EVENTS / 2);
         if (act != ACT_UNUSED) counted++;
      end

      // wait for every transfer and report, then let stragglers show up
      while (pending_strokes.size() != 0 || expected_reports.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("** keyboard_six_key_report_builder_top: PASSED **");
      else
         $display("** keyboard_six_key_report_builder_top: FAILED **");
      $finish;
   end

endmodule

### sim.f
+incdir+hw/rtl
hw/rtl/kbd6_pkg.sv
hw/rtl/kbd6_stream_if.sv
hw/rtl/kbd6_in_reg.sv
hw/rtl/kbd6_slot_logic.sv
hw/rtl/keyboard_six_key_report_builder_top.sv
tb/sv/testbench.sv
